[hw/rtl/ssr_pkg.sv]
// shared types and constants for the servo slew ramp bank
// no dependencies; imported by the controller, datapath, top level and checker
package ssr_pkg;

  localparam int NUM_SERVOS = 8;
  localparam int ID_W       = 3;
  localparam int ANGLE_W    = 8;
  localparam int PERIOD_W   = 10;
  localparam int KIND_W     = 2;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [ANGLE_W-1:0] MID_ANGLE = ANGLE_W'(90);
  localparam logic [ANGLE_W-1:0] MAX_ANGLE = ANGLE_W'(180);

  // command kinds carried on the input tuser
  localparam logic [KIND_W-1:0] KIND_ATTACH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RAMP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic ld_item;
    logic do_ramp;
    logic do_attach;
    logic do_visit;
    logic idx_clr;
  } ssr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [KIND_W-1:0] in_kind;
    logic              in_id_ok;
    logic              out_free;
    logic              step_here;
    logic              idx_last;
  } ssr_sts_t;

  function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] a);
    return (a > MAX_ANGLE) ? MAX_ANGLE : a;
  endfunction

  function automatic logic id_valid(input logic [ID_W-1:0] id);
    return ({1'b0, id} < (ID_W+1)'(NUM_SERVOS));
  endfunction

endpackage

[hw/rtl/ssr_dp.sv]
// datapath: per-servo state registers, sweep index and output register
// depends on ssr_pkg; driven by ssr_ctrl through ssr_cmd_t
module ssr_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [ssr_pkg::IN_DATA_W-1:0]  s_tdata,   // servo_id, angle, step_period
  input  logic [ssr_pkg::KIND_W-1:0]     s_tuser,   // kind
  input  ssr_pkg::ssr_cmd_t              cmd,
  output ssr_pkg::ssr_sts_t              sts,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ssr_pkg::OUT_DATA_W-1:0] m_tdata,   // move_servo, move_angle
  output logic                           m_tlast    // last_move
);
  import ssr_pkg::*;

  logic [ANGLE_W-1:0]  current_angle [NUM_SERVOS];
  logic [ANGLE_W-1:0]  target_angle  [NUM_SERVOS];
  logic                ramping       [NUM_SERVOS];
  logic [PERIOD_W-1:0] wait_left     [NUM_SERVOS];
  logic [PERIOD_W-1:0] ramp_period   [NUM_SERVOS];

  logic [ID_W-1:0]     idx;
  logic [ID_W-1:0]     item_id;
  logic [ANGLE_W-1:0]  item_angle;

  logic [ID_W-1:0]     in_id;
  logic [ANGLE_W-1:0]  in_angle;
  logic [PERIOD_W-1:0] in_period_raw;
  logic [PERIOD_W-1:0] in_period;

  logic [ANGLE_W-1:0]  cur;
  logic [ANGLE_W-1:0]  tgt;
  logic [ANGLE_W-1:0]  new_angle;
  logic                step_here;
  logic                later_step;
  logic                out_free;

  // input field unpacking with angle clamp and zero-period repair
  assign in_id         = s_tdata[ID_W-1:0];
  assign in_angle      = clamp_angle(s_tdata[ID_W+ANGLE_W-1:ID_W]);
  assign in_period_raw = s_tdata[ID_W+ANGLE_W+PERIOD_W-1:ID_W+ANGLE_W];
  assign in_period     = (in_period_raw == '0) ? PERIOD_W'(1) : in_period_raw;

  // servo under the sweep index
  assign cur       = current_angle[idx];
  assign tgt       = target_angle[idx];
  assign step_here = ramping[idx] && (wait_left[idx] == '0);

  always_comb begin
    if (tgt > cur) begin
      new_angle = cur + ANGLE_W'(1);
    end else if (cur != '0) begin
      new_angle = cur - ANGLE_W'(1);
    end else begin
      new_angle = cur;
    end
  end

  // any higher-numbered servo that will step on this tick
  always_comb begin
    later_step = 1'b0;
    for (int j = 0; j < NUM_SERVOS; j++) begin
      if ((ID_W'(j) > idx) && ramping[j] && (wait_left[j] == '0)) begin
        later_step = 1'b1;
      end
    end
  end

  assign out_free = !m_tvalid || m_tready;

  assign sts.in_kind   = s_tuser;
  assign sts.in_id_ok  = id_valid(in_id);
  assign sts.out_free  = out_free;
  assign sts.step_here = step_here;
  assign sts.idx_last  = (idx == ID_W'(NUM_SERVOS - 1));

  // latched attach item
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      item_id    <= in_id;
      item_angle <= in_angle;
    end
  end

  // sweep index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.do_visit) begin
      idx <= idx + ID_W'(1);
    end
  end

  // angle, ramp flag and wait counter per servo
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        current_angle[i] <= MID_ANGLE;
        ramping[i]       <= 1'b0;
        wait_left[i]     <= '0;
      end
    end else if (cmd.do_ramp) begin
      wait_left[in_id] <= '0;
      ramping[in_id]   <= (in_angle != current_angle[in_id]);
    end else if (cmd.do_attach) begin
      current_angle[item_id] <= item_angle;
      ramping[item_id]       <= 1'b0;
    end else if (cmd.do_visit && ramping[idx]) begin
      if (wait_left[idx] != '0) begin
        wait_left[idx] <= wait_left[idx] - PERIOD_W'(1);
      end else begin
        current_angle[idx] <= new_angle;
        if (new_angle == tgt) begin
          ramping[idx] <= 1'b0;
        end else begin
          wait_left[idx] <= ramp_period[idx] - PERIOD_W'(1);
        end
      end
    end
  end

  // ramp target and period, written by ramp commands only
  always_ff @(posedge clk) begin
    if (cmd.do_ramp) begin
      target_angle[in_id] <= in_angle;
      ramp_period[in_id]  <= in_period;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.do_attach || (cmd.do_visit && step_here)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.do_attach) begin
      m_tdata <= OUT_DATA_W'({item_angle, item_id});
      m_tlast <= 1'b1;
    end else if (cmd.do_visit && step_here) begin
      m_tdata <= OUT_DATA_W'({new_angle, idx});
      m_tlast <= !later_step;
    end
  end

endmodule

[hw/rtl/ssr_ctrl.sv]
// controller: accepts commands and sequences attach writes and tick sweeps
// depends on ssr_pkg; drives ssr_dp through ssr_cmd_t
module ssr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  ssr_pkg::ssr_sts_t sts,
  output ssr_pkg::ssr_cmd_t cmd
);
  import ssr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ATTACH,
    ST_SWEEP
  } state_t;

  state_t state;
  logic   accept;
  logic   visit;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  // a stepping servo waits for room in the output register
  assign visit    = (state == ST_SWEEP) && (!sts.step_here || sts.out_free);

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.ld_item   = accept;
    cmd.do_ramp   = accept && (sts.in_kind == KIND_RAMP) && sts.in_id_ok;
    cmd.idx_clr   = accept && (sts.in_kind == KIND_TICK);
    cmd.do_attach = (state == ST_ATTACH) && sts.out_free;
    cmd.do_visit  = visit;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if ((sts.in_kind == KIND_ATTACH) && sts.in_id_ok) begin
              state <= ST_ATTACH;
            end else if (sts.in_kind == KIND_TICK) begin
              state <= ST_SWEEP;
            end
          end
        end
        ST_ATTACH: begin
          if (sts.out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          if (visit && sts.idx_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/servo_slew_ramp_bank.sv]
// top level of the servo slew ramp bank: controller plus datapath
// depends on ssr_pkg, ssr_ctrl and ssr_dp
//
// channel | dir | tdata bits                                   | tuser | tlast
// s_*     | in  | [2:0] servo_id [10:3] angle [20:11] step_per | kind  | -
// m_*     | out | [2:0] move_servo [10:3] move_angle           | -     | last_move
//
// a ramp command completes in its accepting cycle; an attach then writes its
// move from the attach state once the output register has room
// a tick sweeps all eight servos one per cycle through the shared step logic,
// pausing on a stepping servo while the output register is back-pressured
// one command is in work at a time; s_tready is high only while idle
// synchronous reset puts every servo at 90 degrees with no ramp running
module servo_slew_ramp_bank (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ssr_pkg::IN_DATA_W-1:0]  s_tdata,   // servo_id, angle, step_period
  input  logic [ssr_pkg::KIND_W-1:0]     s_tuser,   // kind
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ssr_pkg::OUT_DATA_W-1:0] m_tdata,   // move_servo, move_angle
  output logic                           m_tlast    // last_move
);
  import ssr_pkg::*;

  ssr_cmd_t cmd;
  ssr_sts_t sts;

  // sequencing
  ssr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // servo state and output register
  ssr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

[hw/rtl/ssr_checker.sv]
// port-level checks for the servo slew ramp bank, bound to the top level
// depends on ssr_pkg
module ssr_port_checks (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [ssr_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic [ssr_pkg::KIND_W-1:0]     s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ssr_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import ssr_pkg::*;

  // a stalled transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output payload changed under stall");

  // emitted angles stay in range
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[ID_W+ANGLE_W-1:ID_W] <= MAX_ANGLE))
    else $error("move angle above limit");

  // a ramp command leaves the block ready again at once
  a_ramp_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_RAMP) |=> s_tready)
    else $error("ramp command blocked input");

  // an attach transfer occupies the block while its move is written
  a_attach_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_ATTACH) |=> !s_tready)
    else $error("attach did not occupy the block");

  // a tick sweep keeps the input closed while it visits the servos
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_TICK) |=> !s_tready ##1 !s_tready)
    else $error("tick sweep ended early");

endmodule

bind servo_slew_ramp_bank ssr_port_checks u_ssr_port_checks (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

[tb/ssr_checker.sv]
// move checker for the servo slew ramp bank: predicts every move and compares
// depends on ssr_pkg; instantiated next to the block by tb_top
`timescale 1ns / 1ps

module ssr_checker
  import ssr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // servo_id, angle, step_period
  input  logic [KIND_W-1:0]     s_tuser,   // kind
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // move_servo, move_angle
  input  logic                  m_tlast,   // last_move
  output int unsigned           moves_pending,
  output int unsigned           mismatch_count
);

  typedef struct packed {
    logic [ID_W-1:0]    servo;
    logic [ANGLE_W-1:0] angle;
    logic               last;
  } move_t;

  // private copy of the servo bank
  logic [ANGLE_W-1:0]  pos_deg   [NUM_SERVOS];
  logic [ANGLE_W-1:0]  goal_deg  [NUM_SERVOS];
  logic                slewing   [NUM_SERVOS];
  logic [PERIOD_W-1:0] wait_ms   [NUM_SERVOS];
  logic [PERIOD_W-1:0] period_ms [NUM_SERVOS];

  move_t moves_due[$];

  initial mismatch_count = 0;

  task automatic report_mismatch(input string detail);
    $display("check failed at %0t: %s", $time, detail);
    mismatch_count++;
  endtask

  task automatic reset_bank();
    for (int i = 0; i < NUM_SERVOS; i++) begin
      pos_deg[i]   = MID_ANGLE;
      goal_deg[i]  = '0;
      slewing[i]   = 1'b0;
      wait_ms[i]   = '0;
      period_ms[i] = '0;
    end
    moves_due.delete();
  endtask

  // apply one command to the bank and queue the moves it causes
  task automatic apply_command(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                               input logic [ANGLE_W-1:0] raw_angle,
                               input logic [PERIOD_W-1:0] raw_period);
    logic [ANGLE_W-1:0] ang;
    logic [PERIOD_W-1:0] per;
    move_t batch [NUM_SERVOS];
    move_t mv;
    int n;
    ang = (raw_angle > MAX_ANGLE) ? MAX_ANGLE : raw_angle;
    per = (raw_period == '0) ? PERIOD_W'(1) : raw_period;
    n = 0;
    case (kind)
      KIND_ATTACH: begin
        if (int'(id) < NUM_SERVOS) begin
          pos_deg[id] = ang;
          slewing[id] = 1'b0;
          mv.servo = id;
          mv.angle = ang;
          mv.last  = 1'b1;
          moves_due.push_back(mv);
        end
      end
      KIND_RAMP: begin
        if (int'(id) < NUM_SERVOS) begin
          period_ms[id] = per;
          goal_deg[id]  = ang;
          wait_ms[id]   = '0;
          slewing[id]   = (ang != pos_deg[id]);
        end
      end
      KIND_TICK: begin
        // visit servos in index order, one degree per due servo
        for (int i = 0; i < NUM_SERVOS; i++) begin
          if (slewing[i]) begin
            if (wait_ms[i] != '0) begin
              wait_ms[i] = wait_ms[i] - 1'b1;
            end else begin
              if (goal_deg[i] > pos_deg[i]) pos_deg[i] = pos_deg[i] + 1'b1;
              else if (pos_deg[i] != '0) pos_deg[i] = pos_deg[i] - 1'b1;
              batch[n].servo = ID_W'(i);
              batch[n].angle = pos_deg[i];
              batch[n].last  = 1'b0;
              n++;
              if (pos_deg[i] == goal_deg[i]) slewing[i] = 1'b0;
              else wait_ms[i] = period_ms[i] - 1'b1;
            end
          end
        end
        for (int k = 0; k < n; k++) begin
          if (k == n - 1) batch[k].last = 1'b1;
          moves_due.push_back(batch[k]);
        end
      end
      default: begin
        // unused kind leaves the bank alone
      end
    endcase
  endtask

  // compare one accepted move against the oldest queued one
  task automatic check_move();
    move_t want;
    logic [ID_W-1:0] got_servo;
    logic [ANGLE_W-1:0] got_angle;
    got_servo = m_tdata[ID_W-1:0];
    got_angle = m_tdata[ID_W+ANGLE_W-1:ID_W];
    if (moves_due.size() == 0) begin
      report_mismatch($sformatf("unexpected move servo %0d angle %0d last %0d",
                                got_servo, got_angle, m_tlast));
    end else begin
      want = moves_due.pop_front();
      if (got_servo !== want.servo)
        report_mismatch($sformatf("move_servo got %0d expected %0d", got_servo, want.servo));
      if (got_angle !== want.angle)
        report_mismatch($sformatf("move_angle got %0d expected %0d (servo %0d)",
                                  got_angle, want.angle, want.servo));
      if (m_tlast !== want.last)
        report_mismatch($sformatf("last_move got %0d expected %0d (servo %0d)",
                                  m_tlast, want.last, want.servo));
    end
  endtask

  // watch both channels at every edge
  always @(posedge clk) begin
    if (rst) begin
      reset_bank();
      moves_pending <= 0;
    end else begin
      if (s_tvalid && s_tready)
        apply_command(s_tuser, s_tdata[ID_W-1:0], s_tdata[ID_W+ANGLE_W-1:ID_W],
                      s_tdata[ID_W+ANGLE_W+PERIOD_W-1:ID_W+ANGLE_W]);
      if (m_tvalid && m_tready)
        check_move();
      moves_pending <= moves_due.size();
    end
  end

endmodule

[tb/tb_top.sv]
// top of the servo slew ramp bank testbench: clock, reset, command stimulus
// depends on ssr_pkg, servo_slew_ramp_bank and ssr_checker
`timescale 1ns / 1ps

module tb_top;
  import ssr_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam int unsigned STALL_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS = 246;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // servo_id, angle, step_period
  logic [KIND_W-1:0]     s_tuser;   // kind
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // move_servo, move_angle
  logic                  m_tlast;   // last_move

  int unsigned moves_pending;
  int unsigned mismatch_count;

  int tx_idle_pct;
  int rx_idle_pct;
  int unsigned stall_req_cnt;
  int unsigned stall_seen;
  int unsigned stall_left;
  int unsigned cycle_count;

  servo_slew_ramp_bank u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  ssr_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .moves_pending  (moves_pending),
    .mismatch_count (mismatch_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // long receiver hold-off, counted here and requested by the stimulus
  initial begin
    stall_seen = 0;
    stall_left = 0;
  end
  always @(posedge clk) begin
    if (stall_req_cnt != stall_seen) begin
      stall_seen <= stall_req_cnt;
      stall_left <= STALL_CYCLES;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // receiver side ready
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      m_tready <= (stall_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // offer one command and hold it until the transfer
  task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                          input logic [ANGLE_W-1:0] ang, input logic [PERIOD_W-1:0] per);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= IN_DATA_W'({per, ang, id});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // mostly ticks and ramps so servos keep moving, some attaches and noise
  task automatic send_random();
    int unsigned pick;
    int unsigned roll;
    logic [ANGLE_W-1:0] ang;
    logic [PERIOD_W-1:0] per;
    pick = $urandom_range(99);
    ang = ($urandom_range(99) < 85) ? ANGLE_W'($urandom_range(180))
                                    : ANGLE_W'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 70)      per = PERIOD_W'($urandom_range(3));
    else if (roll < 95) per = PERIOD_W'($urandom_range(20, 4));
    else                per = PERIOD_W'($urandom_range(1023));
    if (pick < 45)      send_cmd(KIND_TICK, ID_W'($urandom), ang, per);
    else if (pick < 75) send_cmd(KIND_RAMP, ID_W'($urandom), ang, per);
    else if (pick < 93) send_cmd(KIND_ATTACH, ID_W'($urandom), ang, per);
    else                send_cmd(KIND_UNUSED, ID_W'($urandom), ang, per);
  endtask

  // stop offering and wait for every queued move, then a settling wait
  task automatic drain_moves();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (moves_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stimulus and verdict
  initial begin
    rst           <= 1'b1;
    s_tvalid      <= 1'b0;
    s_tdata       <= '0;
    s_tuser       <= KIND_ATTACH;
    stall_req_cnt <= 0;
    rx_idle_pct   <= 0;
    tx_idle_pct   = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // field extremes and angle saturation on attach
    send_cmd(KIND_ATTACH, 3'd0, 8'd0, 10'd0);
    send_cmd(KIND_ATTACH, 3'd7, 8'd180, 10'd1023);
    send_cmd(KIND_ATTACH, 3'd3, 8'd255, 10'd0);
    send_cmd(KIND_ATTACH, 3'd5, 8'd181, 10'd0);
    // tick with nothing ramping, then an unused kind
    send_cmd(KIND_TICK, 3'd7, 8'd255, 10'd1023);
    send_cmd(KIND_UNUSED, 3'd7, 8'd255, 10'd1023);
    // target equal to the current angle ends the ramp at once
    send_cmd(KIND_RAMP, 3'd1, 8'd90, 10'd5);
    send_cmd(KIND_TICK, 3'd0, 8'd0, 10'd0);
    // zero period, down ramp, saturated target with longest period
    send_cmd(KIND_RAMP, 3'd0, 8'd3, 10'd0);
    send_cmd(KIND_RAMP, 3'd7, 8'd178, 10'd2);
    send_cmd(KIND_RAMP, 3'd2, 8'd255, 10'd1023);
    send_cmd(KIND_RAMP, 3'd4, 8'd0, 10'd1);
    send_cmd(KIND_RAMP, 3'd6, 8'd92, 10'd3);
    repeat (5) send_cmd(KIND_TICK, 3'd0, 8'd0, 10'd0);
    // attach cancels a running ramp, then ramp back to zero
    send_cmd(KIND_ATTACH, 3'd4, 8'd45, 10'd0);
    send_cmd(KIND_RAMP, 3'd0, 8'd0, 10'd0);
    repeat (4) send_cmd(KIND_TICK, 3'd0, 8'd0, 10'd0);
    drain_moves();

    // random part in three idling phases
    tx_idle_pct = 38;
    rx_idle_pct <= 80;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 90) begin
        drain_moves();
        tx_idle_pct = 80;
        rx_idle_pct <= 38;
      end else if (n == 180) begin
        drain_moves();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        stall_req_cnt <= stall_req_cnt + 1;
      end
      // after the hold-off starts, every servo gets a fast ramp to fill the output
      if (n >= 180 && n < 180 + NUM_SERVOS)
        send_cmd(KIND_RAMP, ID_W'(n - 180), ANGLE_W'($urandom_range(180)), 10'd0);
      else
        send_random();
    end
    drain_moves();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[servo_slew_ramp_bank.f]
hw/rtl/ssr_pkg.sv
hw/rtl/ssr_dp.sv
hw/rtl/ssr_ctrl.sv
hw/rtl/servo_slew_ramp_bank.sv
hw/rtl/ssr_checker.sv
tb/ssr_checker.sv
tb/tb_top.sv
